// ===== sv/cd39_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Code 39 pulse-width decoder.
// No dependencies.
package cd39_pkg;

    localparam int WINDOW_MODULES = 15;
    localparam int PATTERN_COUNT  = 37;
    localparam int CHAR_W         = 6;
    localparam int FILL_W         = 4;
    localparam int TIME_W         = 32;
    localparam int RATIO_W        = 6;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 6'd13;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] time_us;
    } t_cd39_in;

    typedef struct packed {
        logic              fwd_found;
        logic [CHAR_W-1:0] fwd_char;
        logic              rev_found;
        logic [CHAR_W-1:0] rev_char;
    } t_cd39_out;

    // Code 39 module patterns: star, 0-9, A-Z; leftmost module in bit 14
    localparam logic [WINDOW_MODULES-1:0] PATTERNS [PATTERN_COUNT] = '{
        15'b100010111011101, 15'b101000111011101, 15'b111010001010111,
        15'b101110001010111, 15'b111011100010101, 15'b101000111010111,
        15'b111010001110101, 15'b101110001110101, 15'b101000101110111,
        15'b111010001011101, 15'b101110001011101, 15'b111010100010111,
        15'b101110100010111, 15'b111011101000101, 15'b101011100010111,
        15'b111010111000101, 15'b101110111000101, 15'b101010001110111,
        15'b111010100011101, 15'b101110100011101, 15'b101011100011101,
        15'b111010101000111, 15'b101110101000111, 15'b111011101010001,
        15'b101011101000111, 15'b111010111010001, 15'b101110111010001,
        15'b101010111000111, 15'b111010101110001, 15'b101110101110001,
        15'b101011101110001, 15'b111000101010111, 15'b100011101010111,
        15'b111000111010101, 15'b100010111010111, 15'b111000101110101,
        15'b100011101110101
    };

endpackage

// ===== sv/cd39_match.sv =====
`timescale 1ns / 1ps
// Parallel forward and reversed lookup of a 15-module window in the pattern table.
// Depends on cd39_pkg.
module cd39_match (
    input  logic [cd39_pkg::WINDOW_MODULES-1:0] i_window,
    output cd39_pkg::t_cd39_out                 o_result
);

    logic [cd39_pkg::WINDOW_MODULES-1:0] rev_window;

    always_comb begin
        for (int i = 0; i < cd39_pkg::WINDOW_MODULES; i++) begin
            rev_window[i] = i_window[cd39_pkg::WINDOW_MODULES-1-i];
        end
    end

    // scan from the top so the lowest matching index wins
    always_comb begin
        o_result = '0;
        for (int i = cd39_pkg::PATTERN_COUNT - 1; i >= 0; i--) begin
            if (cd39_pkg::PATTERNS[i] == i_window) begin
                o_result.fwd_found = 1'b1;
                o_result.fwd_char  = cd39_pkg::CHAR_W'(i);
            end
            if (cd39_pkg::PATTERNS[i] == rev_window) begin
                o_result.rev_found = 1'b1;
                o_result.rev_char  = cd39_pkg::CHAR_W'(i);
            end
        end
    end

endmodule

// ===== sv/code39_pulse_width_decoder_core.sv =====
`timescale 1ns / 1ps
// Code 39 pulse-width decoder core: edge timing, narrow/wide classing, window match.
// Depends on cd39_pkg and cd39_match.
// A completing edge passes the input register and then the result register before it shows on o_out_valid.
// Throughput: one edge per cycle; the input register only holds when the result waits.
// Reset (synchronous, active low): clears timing state, reference, window, ratio to 13.
module code39_pulse_width_decoder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // edge input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  cd39_pkg::t_cd39_in           i_in_data,
    // result output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output cd39_pkg::t_cd39_out          o_out_data,
    // wide-threshold ratio register
    input  logic                         i_cfg_we,
    input  logic [cd39_pkg::RATIO_W-1:0] i_cfg_wdata
);

    localparam int LHS_W = cd39_pkg::TIME_W + 4;                  // width * 10
    localparam int RHS_W = cd39_pkg::TIME_W + cd39_pkg::RATIO_W;  // ref * ratio
    localparam logic [cd39_pkg::FILL_W-1:0] LAST_POS =
        cd39_pkg::FILL_W'(cd39_pkg::WINDOW_MODULES - 1);

    // ------------------------------------------------------------------
    // Config and edge-timing state
    // ------------------------------------------------------------------
    logic [cd39_pkg::RATIO_W-1:0] r_ratio;
    logic                         r_seen;
    logic [cd39_pkg::TIME_W-1:0]  r_last_time;
    logic [cd39_pkg::TIME_W-1:0]  r_ref;

    // ------------------------------------------------------------------
    // Input register: width and reference of one element.
    // ------------------------------------------------------------------
    logic                         r_s1_v, r_s1_bit;
    logic [cd39_pkg::TIME_W-1:0]  r_s1_width, r_s1_ref;

    // module window state
    logic [cd39_pkg::WINDOW_MODULES-1:0] r_win;
    logic [cd39_pkg::FILL_W-1:0]         r_fill;
    logic                                r_skip;

    logic                         r_out_valid;
    cd39_pkg::t_cd39_out          r_out_data;

    // handshake chain: a register can take new data when empty or draining
    logic out_free, s1_free, s1_go, in_xfer;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_v && out_free;
    assign s1_free    = !r_s1_v || out_free;
    assign o_in_ready = s1_free;
    assign in_xfer    = i_in_valid && s1_free;

    // ------------------------------------------------------------------
    // Edge stage: width since last edge, learn the narrow reference.
    // Level 1 ends a light space (0 modules); level 0 ends a dark bar.
    // Nothing before the first level-1 edge.
    // ------------------------------------------------------------------
    logic [cd39_pkg::TIME_W-1:0] width;
    logic [cd39_pkg::TIME_W-1:0] n_ref;
    logic                        elem_v;

    assign width  = i_in_data.time_us - r_last_time;   // wraps mod 2^32
    assign elem_v = r_seen;
    assign n_ref  = (!i_in_data.level && r_seen && (r_ref == '0)) ? width : r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio     <= cd39_pkg::RATIO_RESET;
            r_seen      <= 1'b0;
            r_last_time <= '0;
            r_ref       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ratio <= i_cfg_wdata;
            end
            if (in_xfer && (r_seen || i_in_data.level)) begin
                r_seen      <= 1'b1;
                r_last_time <= i_in_data.time_us;
                r_ref       <= n_ref;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= in_xfer && elem_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_bit   <= !i_in_data.level;
            r_s1_width <= width;
            r_s1_ref   <= n_ref;
        end
    end

    // ------------------------------------------------------------------
    // Class: width*10 as shift-add, ref*ratio on a 32x6 multiplier,
    // wide when width*10 > ref*ratio
    // ------------------------------------------------------------------
    logic [LHS_W-1:0] lhs;
    logic [RHS_W-1:0] rhs;
    logic             wide;

    assign lhs  = (LHS_W'(r_s1_width) << 3) + (LHS_W'(r_s1_width) << 1);
    assign rhs  = RHS_W'(r_s1_ref) * RHS_W'(r_ratio);
    assign wide = RHS_W'(lhs) > rhs;

    // ------------------------------------------------------------------
    // Window update: place one or three modules. The module after a full
    // window is the intercharacter gap and is dropped. An element spans at
    // most 3 modules, so at most one window completes per element.
    // ------------------------------------------------------------------
    logic [cd39_pkg::WINDOW_MODULES-1:0] n_win, win_snap;
    logic [cd39_pkg::FILL_W-1:0]         n_fill;
    logic                                n_skip, win_full;

    always_comb begin
        n_win    = r_win;
        n_fill   = r_fill;
        n_skip   = r_skip;
        win_full = 1'b0;
        win_snap = r_win;
        for (int k = 0; k < 3; k++) begin
            if (k == 0 || wide) begin
                if (n_skip) begin
                    n_skip = 1'b0;
                end else begin
                    n_win[LAST_POS - n_fill] = r_s1_bit;
                    if (n_fill == LAST_POS) begin
                        n_fill   = '0;
                        n_skip   = 1'b1;
                        win_full = 1'b1;
                        win_snap = n_win;
                    end else begin
                        n_fill = n_fill + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
            r_skip <= 1'b0;
        end else if (s1_go) begin
            r_win  <= n_win;
            r_fill <= n_fill;
            r_skip <= n_skip;
        end
    end

    // ------------------------------------------------------------------
    // Match and result register
    // ------------------------------------------------------------------
    cd39_pkg::t_cd39_out match_res;

    cd39_match u_match (
        .i_window (win_snap),
        .o_result (match_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && win_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && win_full) begin
            r_out_data <= match_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
